>>> sv/dpvv_pkg.sv
// Shared types and constants for the double point vortex velocity block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package dpvv_pkg;

   // 2*pi in Q3.29 and the matching shift.
   localparam int          PI_SHIFT = 29;
   localparam logic [31:0] TWO_PI_Q = 32'd3373259426;

   // Quotient and velocity width.
   localparam int QUOT_W   = 32;
   localparam int VORTICES = 2;
   localparam int LANES    = 4;

   localparam logic [QUOT_W-1:0] POS_LIMIT = {1'b0, {(QUOT_W-1){1'b1}}};
   localparam logic [QUOT_W-1:0] NEG_LIMIT = {1'b1, {(QUOT_W-1){1'b0}}};

   typedef enum logic [2:0] {
      CSR_FIRST_CENTRE_X  = 3'd0,
      CSR_FIRST_CENTRE_Y  = 3'd1,
      CSR_SECOND_CENTRE_X = 3'd2,
      CSR_SECOND_CENTRE_Y = 3'd3,
      CSR_FIRST_STRENGTH  = 3'd4,
      CSR_SECOND_STRENGTH = 3'd5
   } csr_index_type;

   // Per-item flags carried alongside the divisions.
   // Lane 2v is the x component of vortex v, lane 2v+1 its y component.
   typedef struct packed {
      logic [VORTICES-1:0] at_centre;
      logic [LANES-1:0]    sat;
      logic [LANES-1:0]    neg;
   } flags_type;

   // Width of 2*pi*r^2 for a given coordinate width.
   function automatic int den_width(input int coord_width);
      return 2 * (coord_width + 1) + 1 + QUOT_W;
   endfunction

endpackage

`default_nettype wire

>>> sv/dpvv_front.sv
// Front pipeline: offsets, squares, products, 2*pi*r^2 and the overflow test.
// Depends on dpvv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpvv_front
   import dpvv_pkg::*;
#(
   parameter int FRAC_BITS   = 16,
   parameter int COORD_WIDTH = 18
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic [VORTICES-1:0][COORD_WIDTH-1:0]   centre_x,
   input  wire logic [VORTICES-1:0][COORD_WIDTH-1:0]   centre_y,
   input  wire logic [VORTICES-1:0][FRAC_BITS+3:0]     strength,
   input  wire logic                                   in_valid,
   output logic                                        in_ready,
   input  wire logic [COORD_WIDTH-1:0]                 point_x,
   input  wire logic [COORD_WIDTH-1:0]                 point_y,
   output logic                                        out_valid,
   input  wire logic                                   out_ready,
   output logic [VORTICES-1:0][den_width(COORD_WIDTH)-1:0] out_den,
   output logic [LANES-1:0][den_width(COORD_WIDTH)-1:0]    out_rem,
   output flags_type                                   out_flags
);

   localparam int SW        = FRAC_BITS + 4;
   localparam int DW        = COORD_WIDTH + 1;
   localparam int SQ_W      = 2 * DW;
   localparam int R2_W      = SQ_W + 1;
   localparam int LO_W      = R2_W / 2;
   localparam int HI_W      = R2_W - LO_W;
   localparam int DLO_W     = LO_W + 32;
   localparam int DHI_W     = HI_W + 32;
   localparam int DEN_W     = den_width(COORD_WIDTH);
   localparam int PROD_W    = SW + DW;
   localparam int NUM_SHIFT = FRAC_BITS + PI_SHIFT - QUOT_W;
   localparam int NUMH_W    = PROD_W + NUM_SHIFT;
   localparam int CMP_W     = (NUMH_W > DEN_W) ? NUMH_W : DEN_W;
   localparam int STAGES    = 6;

   logic [STAGES-1:0] v_ff;
   logic [STAGES-1:0] v_in;
   logic [STAGES-1:0] ld;

   always_comb begin
      ld[STAGES-1] = !v_ff[STAGES-1] || out_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         ld[i] = !v_ff[i] || ld[i+1];
      end
      for (int i = 0; i < STAGES; i++) begin
         if (ld[i]) begin
            v_in[i] = (i == 0) ? in_valid : v_ff[(i == 0) ? 0 : i - 1];
         end else begin
            v_in[i] = v_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign in_ready  = ld[0];
   assign out_valid = v_ff[STAGES-1];

   // Stage 1: offsets from each centre.
   logic signed [DW-1:0] dx1_ff [VORTICES];
   logic signed [DW-1:0] dy1_ff [VORTICES];

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         for (int v = 0; v < VORTICES; v++) begin
            dx1_ff[v] <= $signed({point_x[COORD_WIDTH-1], point_x})
                       - $signed({centre_x[v][COORD_WIDTH-1], centre_x[v]});
            dy1_ff[v] <= $signed({point_y[COORD_WIDTH-1], point_y})
                       - $signed({centre_y[v][COORD_WIDTH-1], centre_y[v]});
         end
      end
   end

   // Stage 2: squares, strength products and signs.
   logic [DW-1:0]     dxm [VORTICES];
   logic [DW-1:0]     dym [VORTICES];
   logic [SW-1:0]     sm  [VORTICES];
   logic [SQ_W-1:0]   sqx2_ff [VORTICES];
   logic [SQ_W-1:0]   sqy2_ff [VORTICES];
   logic [PROD_W-1:0] prod2_ff [LANES];
   logic [LANES-1:0]  neg2_ff;

   always_comb begin
      for (int v = 0; v < VORTICES; v++) begin
         dxm[v] = dx1_ff[v][DW-1] ? (~dx1_ff[v]) + DW'(1) : dx1_ff[v];
         dym[v] = dy1_ff[v][DW-1] ? (~dy1_ff[v]) + DW'(1) : dy1_ff[v];
         sm[v]  = strength[v][SW-1] ? (~strength[v]) + SW'(1) : strength[v];
      end
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         for (int v = 0; v < VORTICES; v++) begin
            sqx2_ff[v]      <= SQ_W'(dxm[v]) * SQ_W'(dxm[v]);
            sqy2_ff[v]      <= SQ_W'(dym[v]) * SQ_W'(dym[v]);
            prod2_ff[2*v]   <= PROD_W'(sm[v]) * PROD_W'(dym[v]);
            prod2_ff[2*v+1] <= PROD_W'(sm[v]) * PROD_W'(dxm[v]);
            neg2_ff[2*v]    <= strength[v][SW-1] ^ dy1_ff[v][DW-1];
            neg2_ff[2*v+1]  <= ~(strength[v][SW-1] ^ dx1_ff[v][DW-1]);
         end
      end
   end

   // Stage 3: squared radius.
   logic [R2_W-1:0]   r2_3_ff [VORTICES];
   logic [PROD_W-1:0] prod3_ff [LANES];
   logic [LANES-1:0]  neg3_ff;

   always_ff @(posedge clock) begin
      if (ld[2]) begin
         for (int v = 0; v < VORTICES; v++) begin
            r2_3_ff[v] <= R2_W'(sqx2_ff[v]) + R2_W'(sqy2_ff[v]);
         end
         prod3_ff <= prod2_ff;
         neg3_ff  <= neg2_ff;
      end
   end

   // Stage 4: partial products of 2*pi*r^2.
   logic [DLO_W-1:0]    dlo4_ff [VORTICES];
   logic [DHI_W-1:0]    dhi4_ff [VORTICES];
   logic [VORTICES-1:0] zero4_ff;
   logic [PROD_W-1:0]   prod4_ff [LANES];
   logic [LANES-1:0]    neg4_ff;

   always_ff @(posedge clock) begin
      if (ld[3]) begin
         for (int v = 0; v < VORTICES; v++) begin
            dlo4_ff[v]  <= DLO_W'(r2_3_ff[v][LO_W-1:0]) * DLO_W'(TWO_PI_Q);
            dhi4_ff[v]  <= DHI_W'(r2_3_ff[v][R2_W-1:LO_W]) * DHI_W'(TWO_PI_Q);
            zero4_ff[v] <= (r2_3_ff[v] == '0);
         end
         prod4_ff <= prod3_ff;
         neg4_ff  <= neg3_ff;
      end
   end

   // Stage 5: full denominator.
   logic [DEN_W-1:0]    den5_ff [VORTICES];
   logic [VORTICES-1:0] zero5_ff;
   logic [PROD_W-1:0]   prod5_ff [LANES];
   logic [LANES-1:0]    neg5_ff;

   always_ff @(posedge clock) begin
      if (ld[4]) begin
         for (int v = 0; v < VORTICES; v++) begin
            den5_ff[v] <= {dhi4_ff[v], {LO_W{1'b0}}} + DEN_W'(dlo4_ff[v]);
         end
         zero5_ff <= zero4_ff;
         prod5_ff <= prod4_ff;
         neg5_ff  <= neg4_ff;
      end
   end

   // Stage 6: a quotient of 2^32 or more saturates; otherwise the upper
   // numerator bits seed the remainder (the lower 32 bits are all zero).
   logic [CMP_W-1:0] numh [LANES];
   logic [LANES-1:0] sat;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         numh[l] = CMP_W'(prod5_ff[l]) << NUM_SHIFT;
         sat[l]  = numh[l] >= CMP_W'(den5_ff[l >> 1]);
      end
   end

   always_ff @(posedge clock) begin
      if (ld[5]) begin
         for (int v = 0; v < VORTICES; v++) begin
            out_den[v] <= den5_ff[v];
         end
         for (int l = 0; l < LANES; l++) begin
            out_rem[l] <= sat[l] ? '0 : numh[l][DEN_W-1:0];
         end
         out_flags.at_centre <= zero5_ff;
         out_flags.sat       <= sat;
         out_flags.neg       <= neg5_ff;
      end
   end

endmodule

`default_nettype wire

>>> sv/dpvv_cell.sv
// One restoring division step for all four velocity lanes of one item.
// Depends on dpvv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpvv_cell
   import dpvv_pkg::*;
#(
   parameter int DEN_W = 70
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire logic [VORTICES-1:0][DEN_W-1:0]    in_den,
   input  wire logic [LANES-1:0][DEN_W-1:0]       in_rem,
   input  wire logic [LANES-1:0][QUOT_W-1:0]      in_quot,
   input  wire flags_type                         in_flags,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output logic [VORTICES-1:0][DEN_W-1:0]         out_den,
   output logic [LANES-1:0][DEN_W-1:0]            out_rem,
   output logic [LANES-1:0][QUOT_W-1:0]           out_quot,
   output flags_type                              out_flags
);

   logic                            valid_ff;
   logic [LANES-1:0][DEN_W-1:0]     rem_in;
   logic [LANES-1:0][QUOT_W-1:0]    quot_in;
   logic [DEN_W:0]                  trial [LANES];
   logic [DEN_W:0]                  diff  [LANES];
   logic [LANES-1:0]                take;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;

   // The remainder stays below the divisor, so the doubled value fits one
   // extra bit; the numerator bit shifted in is always zero.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         trial[l]   = {in_rem[l], 1'b0};
         diff[l]    = trial[l] - {1'b0, in_den[l >> 1]};
         take[l]    = trial[l] >= {1'b0, in_den[l >> 1]};
         rem_in[l]  = take[l] ? diff[l][DEN_W-1:0] : trial[l][DEN_W-1:0];
         quot_in[l] = {in_quot[l][QUOT_W-2:0], take[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         out_den   <= in_den;
         out_rem   <= rem_in;
         out_quot  <= quot_in;
         out_flags <= in_flags;
      end
   end

endmodule

`default_nettype wire

>>> sv/dpvv_back.sv
// Back end: sign and saturation of each contribution, then the saturated sums.
// Depends on dpvv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpvv_back
   import dpvv_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic [LANES-1:0][QUOT_W-1:0]  in_quot,
   input  wire flags_type                     in_flags,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic signed [QUOT_W-1:0]           vel_x,
   output logic signed [QUOT_W-1:0]           vel_y,
   output logic                               at_centre,
   output logic                               clipped
);

   logic                valid1_ff;
   logic                valid2_ff;
   logic                ld1;
   logic                ld2;
   logic [QUOT_W-1:0]   limit [LANES];
   logic [QUOT_W-1:0]   mag   [LANES];
   logic [QUOT_W-1:0]   part_in [LANES];
   logic [LANES-1:0]    clip_lane;
   logic [QUOT_W-1:0]   part_ff [LANES];
   logic                clip1_ff;
   logic                centre1_ff;
   logic [QUOT_W:0]     sum_x;
   logic [QUOT_W:0]     sum_y;
   logic                ovf_x;
   logic                ovf_y;

   assign ld2       = !valid2_ff || out_ready;
   assign ld1       = !valid1_ff || ld2;
   assign in_ready  = ld1;
   assign out_valid = valid2_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         limit[l] = in_flags.neg[l] ? NEG_LIMIT : POS_LIMIT;
         if (in_flags.sat[l] || (in_quot[l] > limit[l])) begin
            mag[l]       = limit[l];
            clip_lane[l] = !in_flags.at_centre[l >> 1];
         end else begin
            mag[l]       = in_quot[l];
            clip_lane[l] = 1'b0;
         end
         if (in_flags.at_centre[l >> 1]) begin
            part_in[l] = '0;
         end else begin
            part_in[l] = in_flags.neg[l] ? (~mag[l]) + QUOT_W'(1) : mag[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         if (ld1) begin
            valid1_ff <= in_valid;
         end
         if (ld2) begin
            valid2_ff <= valid1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         part_ff    <= part_in;
         clip1_ff   <= |clip_lane;
         centre1_ff <= |in_flags.at_centre;
      end
   end

   assign sum_x = {part_ff[0][QUOT_W-1], part_ff[0]} + {part_ff[2][QUOT_W-1], part_ff[2]};
   assign sum_y = {part_ff[1][QUOT_W-1], part_ff[1]} + {part_ff[3][QUOT_W-1], part_ff[3]};
   assign ovf_x = sum_x[QUOT_W] != sum_x[QUOT_W-1];
   assign ovf_y = sum_y[QUOT_W] != sum_y[QUOT_W-1];

   always_ff @(posedge clock) begin
      if (ld2) begin
         if (ovf_x) begin
            vel_x <= sum_x[QUOT_W] ? NEG_LIMIT : POS_LIMIT;
         end else begin
            vel_x <= sum_x[QUOT_W-1:0];
         end
         if (ovf_y) begin
            vel_y <= sum_y[QUOT_W] ? NEG_LIMIT : POS_LIMIT;
         end else begin
            vel_y <= sum_y[QUOT_W-1:0];
         end
         at_centre <= centre1_ff;
         clipped   <= clip1_ff || ovf_x || ovf_y;
      end
   end

endmodule

`default_nettype wire

>>> sv/double_point_vortex_velocity.sv
// Top level of the double point vortex velocity block.
// Depends on dpvv_pkg, dpvv_front, dpvv_cell and dpvv_back.
`timescale 1ns / 1ps
`default_nettype none

// Each transfer on the req_ channel carries one point; the block returns on
// the rsp_ channel the velocity induced there by two point vortices, each
// contributing strength*(dy,-dx)/(2*pi*r^2), truncated towards zero and
// saturated to signed Q(31-FRAC_BITS).FRAC_BITS, Q15.16 by default, then
// summed with saturation. A point that sits exactly on a centre takes
// nothing from that vortex and raises rsp_at_centre; any saturation raises
// rsp_clipped. The block is fully pipelined: a new point can be taken in
// every cycle while results are taken, and each point passes through six
// front stages for the offsets, squares, products and 2*pi*r^2, a chain of
// 32 division cells that each settle one quotient bit of all four
// components, and two stages for sign, saturation and summing. Every stage
// has its own valid bit, so bubbles close up and the block keeps taking
// points until full while a finished result waits for its transfer. The
// centres and strengths are written through the csr_ port, by index in the
// order first centre x, first centre y, second centre x, second centre y,
// first strength, second strength; other indexes are ignored. They should
// only be changed while no point is in flight.

module double_point_vortex_velocity
   import dpvv_pkg::*;
#(
   parameter int FRAC_BITS   = 16,
   parameter int COORD_WIDTH = 18
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [2:0]                          csr_index,
   input  wire logic [((COORD_WIDTH > FRAC_BITS + 4) ?
                        COORD_WIDTH : FRAC_BITS + 4)-1:0] csr_wdata,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [COORD_WIDTH-1:0]       req_point_x,
   input  wire logic signed [COORD_WIDTH-1:0]       req_point_y,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [QUOT_W-1:0]                 rsp_vel_x,
   output logic signed [QUOT_W-1:0]                 rsp_vel_y,
   output logic                                     rsp_at_centre,
   output logic                                     rsp_clipped
);

   localparam int SW    = FRAC_BITS + 4;
   localparam int DEN_W = den_width(COORD_WIDTH);

   // Configuration registers, with their reset values of 0.25, 0.5, 0.75,
   // 0.5, -0.5 and +0.5.
   logic [VORTICES-1:0][COORD_WIDTH-1:0] centre_x_ff;
   logic [VORTICES-1:0][COORD_WIDTH-1:0] centre_y_ff;
   logic [VORTICES-1:0][SW-1:0]          strength_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_x_ff[0] <= COORD_WIDTH'(64'sd1 <<< (FRAC_BITS - 2));
         centre_y_ff[0] <= COORD_WIDTH'(64'sd1 <<< (FRAC_BITS - 1));
         centre_x_ff[1] <= COORD_WIDTH'(64'sd3 <<< (FRAC_BITS - 2));
         centre_y_ff[1] <= COORD_WIDTH'(64'sd1 <<< (FRAC_BITS - 1));
         strength_ff[0] <= SW'(-(64'sd1 <<< (FRAC_BITS - 1)));
         strength_ff[1] <= SW'(64'sd1 <<< (FRAC_BITS - 1));
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FIRST_CENTRE_X: begin
               centre_x_ff[0] <= csr_wdata[COORD_WIDTH-1:0];
            end
            CSR_FIRST_CENTRE_Y: begin
               centre_y_ff[0] <= csr_wdata[COORD_WIDTH-1:0];
            end
            CSR_SECOND_CENTRE_X: begin
               centre_x_ff[1] <= csr_wdata[COORD_WIDTH-1:0];
            end
            CSR_SECOND_CENTRE_Y: begin
               centre_y_ff[1] <= csr_wdata[COORD_WIDTH-1:0];
            end
            CSR_FIRST_STRENGTH: begin
               strength_ff[0] <= csr_wdata[SW-1:0];
            end
            CSR_SECOND_STRENGTH: begin
               strength_ff[1] <= csr_wdata[SW-1:0];
            end
            default: begin
               // Writes to unused indexes are dropped.
            end
         endcase
      end
   end

   // Links of the division chain; link k feeds cell k.
   logic                                 link_valid [QUOT_W+1];
   logic                                 link_ready [QUOT_W+1];
   logic [VORTICES-1:0][DEN_W-1:0]       link_den   [QUOT_W+1];
   logic [LANES-1:0][DEN_W-1:0]          link_rem   [QUOT_W+1];
   logic [LANES-1:0][QUOT_W-1:0]         link_quot  [QUOT_W+1];
   flags_type                            link_flags [QUOT_W+1];

   dpvv_front #(
      .FRAC_BITS  (FRAC_BITS),
      .COORD_WIDTH(COORD_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .centre_x (centre_x_ff),
      .centre_y (centre_y_ff),
      .strength (strength_ff),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .point_x  (req_point_x),
      .point_y  (req_point_y),
      .out_valid(link_valid[0]),
      .out_ready(link_ready[0]),
      .out_den  (link_den[0]),
      .out_rem  (link_rem[0]),
      .out_flags(link_flags[0])
   );

   // The quotient is built up from nothing, one bit per cell.
   assign link_quot[0] = '0;

   for (genvar k = 0; k < QUOT_W; k++) begin : g_cell
      dpvv_cell #(
         .DEN_W(DEN_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (link_valid[k]),
         .in_ready (link_ready[k]),
         .in_den   (link_den[k]),
         .in_rem   (link_rem[k]),
         .in_quot  (link_quot[k]),
         .in_flags (link_flags[k]),
         .out_valid(link_valid[k+1]),
         .out_ready(link_ready[k+1]),
         .out_den  (link_den[k+1]),
         .out_rem  (link_rem[k+1]),
         .out_quot (link_quot[k+1]),
         .out_flags(link_flags[k+1])
      );
   end

   dpvv_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (link_valid[QUOT_W]),
      .in_ready (link_ready[QUOT_W]),
      .in_quot  (link_quot[QUOT_W]),
      .in_flags (link_flags[QUOT_W]),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .vel_x    (rsp_vel_x),
      .vel_y    (rsp_vel_y),
      .at_centre(rsp_at_centre),
      .clipped  (rsp_clipped)
   );

endmodule

`default_nettype wire

>>> sim/vortex_velocity_checker.sv
// Checker for the double point vortex velocity block: watches the csr_, req_
// and rsp_ ports, predicts each velocity and compares it. Depends on dpvv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vortex_velocity_checker
   import dpvv_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [19:0]        csr_wdata,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic signed [17:0] req_point_x,
   input  wire logic signed [17:0] req_point_y,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic signed [31:0] rsp_vel_x,
   input  wire logic signed [31:0] rsp_vel_y,
   input  wire logic               rsp_at_centre,
   input  wire logic               rsp_clipped,
   output int                      fail_count,
   output int                      velocities_pending
);

   typedef struct {
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic               at_centre;
      logic               clipped;
   } velocity_type;

   velocity_type expected_velocities[$];

   longint centre_x[2], centre_y[2], strength[2];

   // One component of one vortex: |s*d| << (16+29) over 2*pi*r^2, truncated
   // and clamped to the signed 32-bit range.
   function automatic longint induced_component(input longint s, input longint d,
                                                input bit flip, input logic [127:0] den,
                                                inout bit clip);
      bit            neg;
      logic [63:0]   mag_s, mag_d, limit;
      logic [127:0]  num, quot;
      neg   = ((s < 0) != (d < 0)) ^ flip;
      limit = neg ? 64'd2147483648 : 64'd2147483647;
      mag_s = (s < 0) ? -s : s;
      mag_d = (d < 0) ? -d : d;
      num   = (128'(mag_s) * 128'(mag_d)) << (16 + PI_SHIFT);
      quot  = num / den;
      if (quot > 128'(limit)) begin
         quot = 128'(limit);
         clip = 1'b1;
      end
      return neg ? -longint'(quot[63:0]) : longint'(quot[63:0]);
   endfunction

   function automatic longint clamp_sum(input longint a, input longint b, inout bit clip);
      longint s;
      s = a + b;
      if (s > 64'sd2147483647) begin
         clip = 1'b1;
         return 64'sd2147483647;
      end
      if (s < -64'sd2147483648) begin
         clip = 1'b1;
         return -64'sd2147483648;
      end
      return s;
   endfunction

   function automatic velocity_type predict_velocity(input longint px, input longint py);
      velocity_type v;
      longint       part_x[2], part_y[2], dx, dy, r2;
      logic [127:0] den;
      bit           centre, clip;
      centre = 1'b0;
      clip   = 1'b0;
      for (int k = 0; k < 2; k++) begin
         dx = px - centre_x[k];
         dy = py - centre_y[k];
         r2 = dx * dx + dy * dy;
         if (r2 == 0) begin
            // A point on the centre takes nothing from this vortex.
            part_x[k] = 0;
            part_y[k] = 0;
            centre    = 1'b1;
         end else begin
            den       = 128'(r2) * 128'(TWO_PI_Q);
            part_x[k] = induced_component(strength[k], dy, 1'b0, den, clip);
            part_y[k] = induced_component(strength[k], dx, 1'b1, den, clip);
         end
      end
      v.vel_x     = 32'(clamp_sum(part_x[0], part_x[1], clip));
      v.vel_y     = 32'(clamp_sum(part_y[0], part_y[1], clip));
      v.at_centre = centre;
      v.clipped   = clip;
      return v;
   endfunction

   always @(posedge clock) begin
      velocity_type want;
      if (reset) begin
         centre_x[0] = 16384;
         centre_y[0] = 32768;
         centre_x[1] = 49152;
         centre_y[1] = 32768;
         strength[0] = -32768;
         strength[1] = 32768;
         expected_velocities.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FIRST_CENTRE_X:  centre_x[0] = longint'($signed(csr_wdata[17:0]));
               CSR_FIRST_CENTRE_Y:  centre_y[0] = longint'($signed(csr_wdata[17:0]));
               CSR_SECOND_CENTRE_X: centre_x[1] = longint'($signed(csr_wdata[17:0]));
               CSR_SECOND_CENTRE_Y: centre_y[1] = longint'($signed(csr_wdata[17:0]));
               CSR_FIRST_STRENGTH:  strength[0] = longint'($signed(csr_wdata));
               CSR_SECOND_STRENGTH: strength[1] = longint'($signed(csr_wdata));
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_velocities.push_back(predict_velocity(req_point_x, req_point_y));
         if (rsp_valid && rsp_ready) begin
            if (expected_velocities.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result vel_x %0d vel_y %0d", $time,
                        rsp_vel_x, rsp_vel_y);
            end else begin
               want = expected_velocities.pop_front();
               if (rsp_vel_x !== want.vel_x) begin
                  fail_count++;
                  $display("%0t: vel_x expected %0d actual %0d", $time, want.vel_x, rsp_vel_x);
               end
               if (rsp_vel_y !== want.vel_y) begin
                  fail_count++;
                  $display("%0t: vel_y expected %0d actual %0d", $time, want.vel_y, rsp_vel_y);
               end
               if (rsp_at_centre !== want.at_centre) begin
                  fail_count++;
                  $display("%0t: at_centre expected %0b actual %0b", $time,
                           want.at_centre, rsp_at_centre);
               end
               if (rsp_clipped !== want.clipped) begin
                  fail_count++;
                  $display("%0t: clipped expected %0b actual %0b", $time,
                           want.clipped, rsp_clipped);
               end
            end
         end
      end
      velocities_pending = expected_velocities.size();
   end

endmodule

`default_nettype wire

>>> sim/double_point_vortex_velocity_tb.sv
// Testbench top for the double point vortex velocity block: drives points and
// register writes, and gives the verdict. Depends on dpvv_pkg,
// double_point_vortex_velocity and vortex_velocity_checker.
`timescale 1ns / 1ps
`default_nettype none

module double_point_vortex_velocity_tb;
   import dpvv_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_we;
   logic [2:0]         csr_index;
   logic [19:0]        csr_wdata;
   logic               req_valid;
   logic               req_ready;
   logic signed [17:0] req_point_x;
   logic signed [17:0] req_point_y;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_vel_x;
   logic signed [31:0] rsp_vel_y;
   logic               rsp_at_centre;
   logic               rsp_clipped;
   int                 fail_count;
   int                 velocities_pending;
   int                 cycle_count = 0;

   // While steady is set neither side idles.
   bit                 steady = 1'b0;

   // Our own copy of the centres, used to aim points at or near them.
   logic signed [17:0] aim_x[2], aim_y[2];

   always #5 clock = ~clock;

   double_point_vortex_velocity dut (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_vel_x     (rsp_vel_x),
      .rsp_vel_y     (rsp_vel_y),
      .rsp_at_centre (rsp_at_centre),
      .rsp_clipped   (rsp_clipped)
   );

   vortex_velocity_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_point_x        (req_point_x),
      .req_point_y        (req_point_y),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_vel_x          (rsp_vel_x),
      .rsp_vel_y          (rsp_vel_y),
      .rsp_at_centre      (rsp_at_centre),
      .rsp_clipped        (rsp_clipped),
      .fail_count         (fail_count),
      .velocities_pending (velocities_pending)
   );

   // The receiver refuses a transfer with a chance of roughly 27 percent,
   // except during the steady stretch.
   always @(posedge clock) begin
      rsp_ready <= steady ? 1'b1 : ($urandom_range(99) >= 27);
   end

   // Watchdog: a hung handshake must not run forever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Writes all six registers back to back, then lowers the write enable. The
   // two unused indexes are written as well; the block must ignore them.
   task automatic load_vortices(input logic signed [17:0] x0, input logic signed [17:0] y0,
                                input logic signed [17:0] x1, input logic signed [17:0] y1,
                                input logic signed [19:0] s0, input logic signed [19:0] s1);
      logic [19:0] values[8];
      values[CSR_FIRST_CENTRE_X]  = 20'(x0);
      values[CSR_FIRST_CENTRE_Y]  = 20'(y0);
      values[CSR_SECOND_CENTRE_X] = 20'(x1);
      values[CSR_SECOND_CENTRE_Y] = 20'(y1);
      values[CSR_FIRST_STRENGTH]  = s0;
      values[CSR_SECOND_STRENGTH] = s1;
      values[3'(CSR_SECOND_STRENGTH) + 3'd1] = 20'($urandom);
      values[3'(CSR_SECOND_STRENGTH) + 3'd2] = 20'($urandom);
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= values[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      aim_x[0] = x0;
      aim_y[0] = y0;
      aim_x[1] = x1;
      aim_y[1] = y1;
   endtask

   // Offers one point and returns at the edge of its transfer. The ready
   // signal is looked at on the falling edge, where it is settled.
   task automatic send_point(input logic signed [17:0] x, input logic signed [17:0] y);
      int gap;
      gap = 0;
      while (!steady && $urandom_range(99) < 27)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      @(negedge clock);
      while (!req_ready)
         @(negedge clock);
      @(posedge clock);
   endtask

   // Holds the sender back until every outstanding velocity has been
   // returned, then lets the pipeline settle a little longer.
   task automatic drain;
      req_valid <= 1'b0;
      @(negedge clock);
      while (velocities_pending != 0)
         @(negedge clock);
      repeat (45) @(posedge clock);
   endtask

   // Points on or close to a centre about two times in five, where the interesting
   // arithmetic lives, with the rest spread over the whole plane.
   task automatic send_random_point;
      int pick, k;
      pick = $urandom_range(99);
      k    = $urandom_range(1);
      if (pick < 8)
         send_point(aim_x[k], aim_y[k]);
      else if (pick < 40)
         send_point(aim_x[k] + 18'($signed(9'($urandom))),
                    aim_y[k] + 18'($signed(9'($urandom))));
      else
         send_point(18'($urandom), 18'($urandom));
   endtask

   initial begin
      logic signed [19:0] s0, s1;
      reset       <= 1'b1;
      csr_we      <= 1'b0;
      csr_index   <= '0;
      csr_wdata   <= '0;
      req_valid   <= 1'b0;
      req_point_x <= '0;
      req_point_y <= '0;
      rsp_ready   <= 1'b0;
      aim_x[0] = 18'sd16384;
      aim_y[0] = 18'sd32768;
      aim_x[1] = 18'sd49152;
      aim_y[1] = 18'sd32768;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: the origin, three corners of the coordinate range and both centres.
      send_point(18'sd0, 18'sd0);
      send_point(-18'sd131072, -18'sd131072);
      send_point(18'sd131071, 18'sd131071);
      send_point(-18'sd131072, 18'sd131071);
      send_point(18'sd16384, 18'sd32768);
      send_point(18'sd49152, 18'sd32768);
      drain();

      // Both centres at the origin with the largest strengths: a point on
      // both at once, and neighbours close enough to saturate.
      load_vortices(18'sd0, 18'sd0, 18'sd0, 18'sd0, 20'sd524287, -20'sd524288);
      send_point(18'sd0, 18'sd0);
      send_point(18'sd1, 18'sd0);
      send_point(18'sd0, 18'sd1);
      send_point(-18'sd1, -18'sd1);
      drain();

      // Centres in opposite corners, both strengths at their minimum.
      load_vortices(-18'sd131072, -18'sd131072, 18'sd131071, 18'sd131071,
                    -20'sd524288, -20'sd524288);
      send_point(-18'sd131072, -18'sd131071);
      send_point(18'sd131071, 18'sd131070);
      send_point(18'sd0, 18'sd0);
      drain();

      // A saturated contribution plus another of the same sign overflows the sum.
      load_vortices(18'sd0, 18'sd0, 18'sd0, 18'sd2, 20'sd524287, 20'sd524287);
      send_point(18'sd1, 18'sd0);
      send_point(18'sd0, 18'sd1);
      send_point(18'sd0, 18'sd3);
      send_point(-18'sd1, 18'sd2);
      drain();

      // Random phases, each with its own register setting.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: load_vortices(18'sd16384, 18'sd32768, 18'sd49152, 18'sd32768,
                             -20'sd32768, 20'sd32768);
            1: load_vortices(18'sd131071, -18'sd131072, -18'sd131072, 18'sd131071,
                             20'sd524287, -20'sd524288);
            default: begin
               // Small strengths often, so that most results stay unsaturated.
               s0 = ($urandom_range(1) == 0) ? 20'($signed(12'($urandom))) : 20'($urandom);
               s1 = ($urandom_range(1) == 0) ? 20'($signed(12'($urandom))) : 20'($urandom);
               load_vortices(18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom),
                             s0, s1);
            end
         endcase
         steady = (phase == 2);
         for (int n = 0; n < 225; n++) begin
            send_random_point();
            // Once in the run the sender waits for the pipeline to empty.
            if (phase == 3 && n == 100)
               drain();
         end
         steady = 1'b0;
         drain();
      end

      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire

>>> double_point_vortex_velocity.f
sv/dpvv_pkg.sv
sv/dpvv_front.sv
sv/dpvv_cell.sv
sv/dpvv_back.sv
sv/double_point_vortex_velocity.sv
sim/vortex_velocity_checker.sv
sim/double_point_vortex_velocity_tb.sv
